// ===== design/rigr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes and reset constants of the grid resampler.
// No dependencies; imported by the front end, the back end and the top level.
package rigr_pkg;

    localparam int MAX_RUN_DEF    = 64;
    localparam int DEPTH_BITS_DEF = 48;

    localparam logic [1:0] CFG_MAX_GAP    = 2'd0;
    localparam logic [1:0] CFG_GRID_START = 2'd1;
    localparam logic [1:0] CFG_GRID_STEP  = 2'd2;
    localparam logic [1:0] CFG_GRID_END   = 2'd3;

    localparam logic [15:0] RST_MAX_GAP    = 16'd3600;
    localparam logic [31:0] RST_GRID_START = 32'd0;
    localparam logic [16:0] RST_GRID_STEP  = 17'd300;
    localparam logic [31:0] RST_GRID_END   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] max_gap;
        logic [31:0] grid_start;
        logic [16:0] grid_step;
        logic [31:0] grid_end;
    } t_cfg;

endpackage

// ===== design/rigr_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for rate samples and grid results.
// No dependencies.
interface rigr_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] sample_time;
    logic [15:0] rate;
    modport source (output valid, func, sample_time, rate, input ready);
    modport sink   (input valid, func, sample_time, rate, output ready);
endinterface

interface rigr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] grid_time;
    logic [47:0] period_accum;
    logic        last_of_run;
    logic        overflow;
    modport source (output valid, grid_time, period_accum, last_of_run, overflow, input ready);
    modport sink   (input valid, grid_time, period_accum, last_of_run, overflow, output ready);
endinterface

// ===== design/rigr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, integrates depth points, queues segment jobs.
// Depends on rigr_pkg and rigr_in_if.
module rigr_front #(
    parameter int DEPTH_BITS = rigr_pkg::DEPTH_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rigr_in_if.sink                           i_in,
    input  rigr_pkg::t_cfg                    i_cfg,
    input  logic                              i_full,
    output logic                              o_push,
    output logic [3*32+2*DEPTH_BITS-1:0]      o_job,
    output logic                              o_fresh
);
    import rigr_pkg::*;

    typedef struct packed {
        logic [31:0]           limit;
        logic [31:0]           ta;
        logic [31:0]           tb;
        logic [DEPTH_BITS-1:0] da;
        logic [DEPTH_BITS-1:0] db;
    } t_job;

    logic [31:0]           r_older, n_older, r_prev, n_prev;
    logic [15:0]           r_prate, n_prate;
    logic [1:0]            r_seen, n_seen;
    logic [DEPTH_BITS-1:0] r_pdepth, n_pdepth;
    logic                  r_fin, n_fin;

    logic                  acc;
    logic [31:0]           gap;
    logic [16:0]           cap, gcl;
    logic [32:0]           prod;
    logic [DEPTH_BITS:0]   sum;
    logic [DEPTH_BITS-1:0] nd;
    t_job                  job;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;
    assign o_fresh    = (r_seen == 2'd0) && !r_fin;
    assign o_job      = job;

    assign gap  = i_in.sample_time - r_older;
    assign cap  = {i_cfg.max_gap, 1'b0};
    assign gcl  = (gap > 32'(cap)) ? cap : gap[16:0];
    assign prod = 33'(gcl) * 33'(r_prate);
    assign sum  = {1'b0, r_pdepth} + (DEPTH_BITS+1)'(prod);
    assign nd   = sum[DEPTH_BITS] ? '1 : sum[DEPTH_BITS-1:0];

    always_comb begin
        n_older  = r_older;
        n_prev   = r_prev;
        n_prate  = r_prate;
        n_seen   = r_seen;
        n_pdepth = r_pdepth;
        n_fin    = r_fin;
        o_push   = 1'b0;
        job      = '0;
        if (acc && !r_fin) begin
            if (i_in.func) begin
                n_fin    = 1'b1;
                o_push   = 1'b1;
                job.limit = i_cfg.grid_end;
                job.da    = r_pdepth;
                job.db    = r_pdepth;
            end else if (r_seen == 2'd0) begin
                n_prev    = i_in.sample_time;
                n_prate   = i_in.rate;
                n_pdepth  = '0;
                n_seen    = 2'd1;
                o_push    = 1'b1;
                job.limit = i_in.sample_time;
                job.ta    = i_in.sample_time;
                job.tb    = i_in.sample_time;
            end else if (i_in.sample_time > r_prev) begin
                n_older = r_prev;
                n_prev  = i_in.sample_time;
                n_prate = i_in.rate;
                if (r_seen == 2'd1) begin
                    n_seen = 2'd2;
                end else begin
                    n_pdepth  = nd;
                    o_push    = 1'b1;
                    job.limit = r_prev;
                    job.ta    = r_older;
                    job.tb    = r_prev;
                    job.da    = r_pdepth;
                    job.db    = nd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older  <= '0;
            r_prev   <= '0;
            r_prate  <= '0;
            r_seen   <= '0;
            r_pdepth <= '0;
            r_fin    <= 1'b0;
        end else begin
            r_older  <= n_older;
            r_prev   <= n_prev;
            r_prate  <= n_prate;
            r_seen   <= n_seen;
            r_pdepth <= n_pdepth;
            r_fin    <= n_fin;
        end
    end
endmodule

// ===== design/rigr_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between front and back.
// No package dependencies.
module rigr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ===== design/rigr_muldiv.sv =====
`timescale 1ns / 1ps
// Serial unit for floor(x * dd / dt): shift-add multiply, then restoring divide.
// No package dependencies.
module rigr_muldiv #(
    parameter int DEPTH_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_x,
    input  logic [DEPTH_BITS-1:0] i_dd,
    input  logic [31:0]           i_dt,
    output logic                  o_done,
    output logic [DEPTH_BITS-1:0] o_q
);
    localparam int PW = DEPTH_BITS + 32;
    localparam int CW = $clog2(PW + 1);
    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;

    logic [1:0]            r_state;
    logic [CW-1:0]         r_cnt;
    logic [31:0]           r_x, r_dt;
    logic [DEPTH_BITS-1:0] r_dd, r_q;
    logic [PW-1:0]         r_p;
    logic [31:0]           r_rem;
    logic                  r_done;
    logic [32:0]           rem_n;
    logic                  qbit;

    assign rem_n  = {r_rem, r_p[PW-1]};
    assign qbit   = (rem_n >= {1'b0, r_dt});
    assign o_done = r_done;
    assign o_q    = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_state <= M_MUL;
                        r_cnt   <= '0;
                    end
                end
                M_MUL: begin
                    if (r_cnt == CW'(31)) begin
                        r_state <= M_DIV;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                M_DIV: begin
                    if (r_cnt == CW'(PW - 1)) begin
                        r_state <= M_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                r_x   <= i_x;
                r_dd  <= i_dd;
                r_dt  <= i_dt;
                r_p   <= '0;
                r_rem <= '0;
                r_q   <= r_q;
            end
            M_MUL: begin
                r_p <= {r_p[PW-2:0], 1'b0} + (r_x[31] ? PW'(r_dd) : PW'(0));
                r_x <= {r_x[30:0], 1'b0};
            end
            M_DIV: begin
                r_rem <= qbit ? 32'(rem_n - {1'b0, r_dt}) : rem_n[31:0];
                r_p   <= {r_p[PW-2:0], 1'b0};
                r_q   <= {r_q[DEPTH_BITS-2:0], qbit};
            end
            default: r_p <= r_p;
        endcase
    end
endmodule

// ===== design/rigr_back.sv =====
`timescale 1ns / 1ps
// Back end: walks grid points of each queued segment and emits increments.
// Depends on rigr_pkg, rigr_out_if and rigr_muldiv.
module rigr_back #(
    parameter int DEPTH_BITS = rigr_pkg::DEPTH_BITS_DEF,
    parameter int MAX_RUN    = rigr_pkg::MAX_RUN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rigr_pkg::t_cfg                i_cfg,
    input  logic                          i_load_start,
    input  logic [3*32+2*DEPTH_BITS-1:0]  i_job,
    input  logic                          i_empty,
    output logic                          o_pop,
    rigr_out_if.source                    o_out
);
    import rigr_pkg::*;

    localparam int NW = $clog2(MAX_RUN + 1);
    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_CHK   = 3'd1;
    localparam logic [2:0] B_CWAIT = 3'd2;
    localparam logic [2:0] B_SPAN  = 3'd3;
    localparam logic [2:0] B_EVAL  = 3'd4;
    localparam logic [2:0] B_PWAIT = 3'd5;
    localparam logic [2:0] B_EMIT  = 3'd6;
    localparam logic [2:0] B_FIN   = 3'd7;

    typedef struct packed {
        logic [31:0]           limit;
        logic [31:0]           ta;
        logic [31:0]           tb;
        logic [DEPTH_BITS-1:0] da;
        logic [DEPTH_BITS-1:0] db;
    } t_job;

    logic [2:0]            r_state;
    t_job                  r_job;
    logic [32:0]           r_next, r_count, r_span;
    logic [31:0]           r_t;
    logic [NW-1:0]         r_n, r_k;
    logic                  r_ovf, r_tail;
    logic [DEPTH_BITS-1:0] r_d, r_last;
    logic                  r_ovalid;
    logic [31:0]           r_otime;
    logic [47:0]           r_oacc;
    logic                  r_olast, r_oovf;

    logic [16:0]           step;
    logic [31:0]           lim;
    logic [32:0]           cnt_n;
    logic [31:0]           tlast;
    logic [DEPTH_BITS-1:0] diff;
    logic                  out_free;
    logic                  md_start, md_done;
    logic [31:0]           md_x, md_dt;
    logic [DEPTH_BITS-1:0] md_dd, md_q;

    assign step     = (i_cfg.grid_step == '0) ? 17'd1 : i_cfg.grid_step;
    assign lim      = (r_job.limit > i_cfg.grid_end) ? i_cfg.grid_end : r_job.limit;
    assign cnt_n    = 33'(md_q) + 33'd1;
    assign tlast    = 32'(r_next + r_span - 33'(step));
    assign diff     = (r_d >= r_last) ? r_d - r_last : '0;
    assign out_free = !r_ovalid || o_out.ready;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;

    assign o_out.valid        = r_ovalid;
    assign o_out.grid_time    = r_otime;
    assign o_out.period_accum = r_oacc;
    assign o_out.last_of_run  = r_olast;
    assign o_out.overflow     = r_oovf;

    always_comb begin
        md_start = 1'b0;
        md_x     = r_t - r_job.ta;
        md_dd    = r_job.db - r_job.da;
        md_dt    = r_job.tb - r_job.ta;
        if (r_state == B_CHK) begin
            md_start = (r_next <= {1'b0, lim});
            md_x     = 32'd1;
            md_dd    = DEPTH_BITS'(lim - r_next[31:0]);
            md_dt    = 32'(step);
        end else if (r_state == B_EVAL) begin
            md_start = (r_t > r_job.ta) && (r_t < r_job.tb);
        end
    end

    rigr_muldiv #(.DEPTH_BITS(DEPTH_BITS)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_x     (md_x),
        .i_dd    (md_dd),
        .i_dt    (md_dt),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_next   <= {1'b0, RST_GRID_START};
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == B_EMIT && !r_tail && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_load_start) begin
                r_next <= {1'b0, i_cfg.grid_start};
            end else if (r_state == B_FIN) begin
                r_next <= r_next + r_span;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= B_CHK;
                    end
                end
                B_CHK: begin
                    r_state <= md_start ? B_CWAIT : B_IDLE;
                end
                B_CWAIT: begin
                    if (md_done) begin
                        r_state <= B_SPAN;
                    end
                end
                B_SPAN:  r_state <= B_EVAL;
                B_EVAL: begin
                    r_state <= md_start ? B_PWAIT : B_EMIT;
                end
                B_PWAIT: begin
                    if (md_done) begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (r_tail) begin
                        r_last  <= r_d;
                        r_state <= B_FIN;
                    end else if (out_free) begin
                        r_last   <= r_d;
                        if (r_k == r_n - 1'b1) begin
                            r_state <= r_ovf ? B_EVAL : B_FIN;
                        end else begin
                            r_state <= B_EVAL;
                        end
                    end
                end
                B_FIN: begin
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
            end
            B_CHK: begin
                r_t    <= r_next[31:0];
                r_tail <= 1'b0;
                r_k    <= '0;
            end
            B_CWAIT: begin
                r_count <= cnt_n;
                r_ovf   <= (cnt_n > 33'(MAX_RUN));
                r_n     <= (cnt_n > 33'(MAX_RUN)) ? NW'(MAX_RUN) : NW'(cnt_n);
            end
            B_SPAN: begin
                r_span <= 33'(r_count * 33'(step));
            end
            B_EVAL: begin
                if (r_t <= r_job.ta) begin
                    r_d <= r_job.da;
                end else if (r_t >= r_job.tb) begin
                    r_d <= r_job.db;
                end
            end
            B_PWAIT: begin
                r_d <= r_job.da + md_q;
            end
            B_EMIT: begin
                if (!r_tail && out_free) begin
                    r_otime <= r_t;
                    r_oacc  <= 48'(diff);
                    r_olast <= (r_k == r_n - 1'b1);
                    r_oovf  <= r_ovf;
                    r_k     <= r_k + 1'b1;
                    if (r_k == r_n - 1'b1 && r_ovf) begin
                        r_t    <= tlast;
                        r_tail <= 1'b1;
                    end else begin
                        r_t <= r_t + 32'(step);
                    end
                end
            end
            default: r_t <= r_t;
        endcase
    end
endmodule

// ===== design/rate_integrator_grid_resampler_top.sv =====
`timescale 1ns / 1ps
// Rate integrator with linear resampling onto a fixed time grid.
// A job popped from the queue first gets its grid-point count from the shared serial
// multiply/divide unit in the back end, then one evaluation per emitted grid point, which
// uses the same unit only when the point lies strictly inside the segment; output
// back-pressure stalls emission, and a new job is popped only once the back end is idle. A run
// that hits the cap adds one more evaluation. Reset: synchronous, active low, config to defaults.
module rate_integrator_grid_resampler_top #(
    parameter int MAX_RUN    = rigr_pkg::MAX_RUN_DEF,
    parameter int DEPTH_BITS = rigr_pkg::DEPTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    rigr_in_if.sink     i_in,
    rigr_out_if.source  o_out
);
    import rigr_pkg::*;

    localparam int JW = 3 * 32 + 2 * DEPTH_BITS;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    t_cfg           r_cfg;
    logic           r_load_start;
    logic           fresh;

    // Front-to-back job queue.
    logic           push, pop, q_empty, q_full;
    logic [JW-1:0]  job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_gap    <= RST_MAX_GAP;
            r_cfg.grid_start <= RST_GRID_START;
            r_cfg.grid_step  <= RST_GRID_STEP;
            r_cfg.grid_end   <= RST_GRID_END;
            r_load_start     <= 1'b0;
        end else begin
            // Reload the grid origin only before any sample or flush was taken.
            r_load_start <= i_cfg_we && (i_cfg_idx == CFG_GRID_START) && fresh;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_GAP:    r_cfg.max_gap    <= i_cfg_data[15:0];
                    CFG_GRID_START: r_cfg.grid_start <= i_cfg_data;
                    CFG_GRID_STEP:  r_cfg.grid_step  <= i_cfg_data[16:0];
                    CFG_GRID_END:   r_cfg.grid_end   <= i_cfg_data;
                    default:        r_cfg            <= r_cfg;
                endcase
            end
        end
    end

    // Front: classify each transaction and build the segment job.
    rigr_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (job_in),
        .o_fresh (fresh)
    );

    rigr_fifo #(.WIDTH(JW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: walk the grid over the segment and drive the output register.
    rigr_back #(.DEPTH_BITS(DEPTH_BITS), .MAX_RUN(MAX_RUN)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_load_start (r_load_start),
        .i_job        (job_out),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_out        (o_out)
    );
endmodule

// ===== design/rigr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the grid resampler, bound to the top level.
// Depends on rate_integrator_grid_resampler_top.
module rigr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_grid_time,
    input logic        i_last,
    input logic        i_ovf
);
    logic        r_seen, r_plast, r_povf;
    logic [31:0] r_ptime;
    logic        acc;

    assign acc = i_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_plast <= 1'b1;
            r_povf  <= 1'b0;
            r_ptime <= '0;
        end else if (acc) begin
            r_seen  <= 1'b1;
            r_plast <= i_last;
            r_povf  <= i_ovf;
            r_ptime <= i_grid_time;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result shown after reset");

    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_seen |-> i_grid_time > r_ptime)
        else $error("grid time not increasing");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !r_plast |-> i_ovf == r_povf)
        else $error("overflow flag changed within a run");
endmodule

bind rate_integrator_grid_resampler_top rigr_checker u_rigr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_grid_time (o_out.grid_time),
    .i_last      (o_out.last_of_run),
    .i_ovf       (o_out.overflow)
);
